FILE: sv/cacp_pkg.sv
// shared types and constants of the call auction clearing price block
package cacp_pkg;

  localparam int PRICE_W = 10;
  localparam int VOL_W   = 20;

  localparam logic [VOL_W-1:0] VOL_MAX = '1;

  typedef enum logic [1:0] {
    OP_ADD_BID = 2'd0,
    OP_ADD_ASK = 2'd1,
    OP_SOLVE   = 2'd2,
    OP_CLEAR   = 2'd3
  } op_e;

  typedef struct packed {
    op_e                operation;
    logic [PRICE_W-1:0] price;
  } in_item_t;

  typedef struct packed {
    logic [PRICE_W-1:0] clear_price;
    logic [VOL_W-1:0]   matched_demand;
    logic [VOL_W-1:0]   matched_supply;
    logic               crossed;
  } out_item_t;

  // read address source of a histogram ram
  typedef enum logic [1:0] {
    RSEL_IN  = 2'd0,
    RSEL_PTR = 2'd1,
    RSEL_G   = 2'd2,
    RSEL_PG  = 2'd3
  } rsel_e;

  // volume register update
  typedef enum logic [1:0] {
    ACC_NONE = 2'd0,
    ACC_SUM  = 2'd1,
    ACC_STEP = 2'd2
  } acc_e;

  // source of a result
  typedef enum logic [1:0] {
    RES_ZERO = 2'd0,
    RES_CUR  = 2'd1,
    RES_PREV = 2'd2
  } res_e;

  typedef struct packed {
    logic  load_item;
    logic  book_clear;
    logic  ptr_zero;
    logic  ptr_inc;
    logic  clr_wr;
    logic  add_wr;
    logic  bid_rd;
    rsel_e bid_rsel;
    logic  ask_rd;
    rsel_e ask_rsel;
    acc_e  acc;
    logic  walk_init;
    logic  step;
    logic  out_load;
    res_e  out_sel;
  } cmd_t;

  typedef struct packed {
    logic crossed;
    logic ptr_at_hi;
    logic ptr_at_end;
    logic d_eq_s;
    logic flip;
    logic dir_up;
    logic prev_better;
  } sts_t;

endpackage

FILE: sv/cacp_ram.sv
// generic simple dual port ram with registered read
module cacp_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 1024,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/cacp_ctrl.sv
// controller state machine of the call auction clearing price block
module cacp_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  cacp_pkg::op_e   op_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  cacp_pkg::sts_t  sts_i,
  output cacp_pkg::cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_WR,
    S_SOLVE,
    S_SUM,
    S_SUM_END,
    S_CHK,
    S_PICK,
    S_STEP_RD,
    S_STEP_UPD,
    S_EMIT,
    S_CLEAR
  } state_e;

  state_e          state_q, state_d;
  logic            out_valid_q, out_valid_d;
  cacp_pkg::res_e  sel_q, sel_d;
  cacp_pkg::cmd_t  cmd;
  logic            in_ready;

  // next state and datapath commands
  always_comb begin
    cmd          = '0;
    cmd.bid_rsel = cacp_pkg::RSEL_IN;
    cmd.ask_rsel = cacp_pkg::RSEL_IN;
    cmd.acc      = cacp_pkg::ACC_NONE;
    cmd.out_sel  = sel_q;
    state_d      = state_q;
    sel_d        = sel_q;
    in_ready     = 1'b0;
    out_valid_d  = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid_i) begin
          cmd.load_item = 1'b1;
          unique case (op_i) inside
            cacp_pkg::OP_ADD_BID, cacp_pkg::OP_ADD_ASK: begin
              state_d = S_ADD_WR;
            end
            cacp_pkg::OP_SOLVE: begin
              state_d = S_SOLVE;
            end
            cacp_pkg::OP_CLEAR: begin
              cmd.book_clear = 1'b1;
              cmd.ptr_zero   = 1'b1;
              state_d        = S_CLEAR;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_ADD_WR: begin
        cmd.add_wr = 1'b1;
        state_d    = S_IDLE;
      end
      S_SOLVE: begin
        if (sts_i.crossed) begin
          cmd.walk_init = 1'b1;
          state_d       = S_SUM;
        end else begin
          sel_d   = cacp_pkg::RES_ZERO;
          state_d = S_EMIT;
        end
      end
      S_SUM: begin
        cmd.bid_rd   = 1'b1;
        cmd.bid_rsel = cacp_pkg::RSEL_PTR;
        cmd.ask_rd   = 1'b1;
        cmd.ask_rsel = cacp_pkg::RSEL_G;
        cmd.acc      = cacp_pkg::ACC_SUM;
        cmd.ptr_inc  = 1'b1;
        if (sts_i.ptr_at_hi) begin
          state_d = S_SUM_END;
        end
      end
      S_SUM_END: begin
        cmd.acc = cacp_pkg::ACC_SUM;
        state_d = S_CHK;
      end
      S_CHK: begin
        if (sts_i.d_eq_s) begin
          sel_d   = cacp_pkg::RES_CUR;
          state_d = S_EMIT;
        end else if (sts_i.flip) begin
          state_d = S_PICK;
        end else begin
          cmd.step = 1'b1;
          state_d  = S_STEP_RD;
        end
      end
      S_PICK: begin
        sel_d   = sts_i.prev_better ? cacp_pkg::RES_PREV : cacp_pkg::RES_CUR;
        state_d = S_EMIT;
      end
      S_STEP_RD: begin
        cmd.bid_rd   = 1'b1;
        cmd.bid_rsel = sts_i.dir_up ? cacp_pkg::RSEL_PG : cacp_pkg::RSEL_G;
        cmd.ask_rd   = 1'b1;
        cmd.ask_rsel = sts_i.dir_up ? cacp_pkg::RSEL_G : cacp_pkg::RSEL_PG;
        state_d      = S_STEP_UPD;
      end
      S_STEP_UPD: begin
        cmd.acc = cacp_pkg::ACC_STEP;
        state_d = S_CHK;
      end
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd.out_load = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_CLEAR: begin
        cmd.clr_wr  = 1'b1;
        cmd.ptr_inc = 1'b1;
        if (sts_i.ptr_at_end) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state and registered outputs, reset starts the clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
      sel_q       <= cacp_pkg::RES_ZERO;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      sel_q       <= sel_d;
    end
  end

  assign in_ready_o  = in_ready;
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

FILE: sv/cacp_dp.sv
// datapath: histograms, book extremes, walk registers and result register
module cacp_dp #(
  parameter int PRICE_LEVELS = 1024,
  parameter int COUNT_BITS   = 20
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cacp_pkg::in_item_t  in_item_i,
  input  cacp_pkg::cmd_t      cmd_i,
  output cacp_pkg::sts_t      sts_o,
  output cacp_pkg::out_item_t out_item_o
);

  localparam int PW     = cacp_pkg::PRICE_W;
  localparam int VW     = cacp_pkg::VOL_W;
  localparam int ADDR_W = $clog2(PRICE_LEVELS);
  localparam int ACC_W  = COUNT_BITS + ADDR_W + 1;
  localparam int G_W    = PW + 2;
  localparam int CMP_W  = (ACC_W > VW) ? ACC_W : VW;
  localparam logic signed [G_W-1:0] G_ONE = 1;

  function automatic logic g_in_range(logic signed [G_W-1:0] v);
    return !v[G_W-1] && (int'(v) < PRICE_LEVELS);
  endfunction

  function automatic logic [ADDR_W-1:0] g_addr(logic signed [G_W-1:0] v);
    return ADDR_W'(v[G_W-2:0]);
  endfunction

  function automatic logic [VW-1:0] sat_vol(logic [ACC_W-1:0] v);
    logic [CMP_W-1:0] w;
    w = CMP_W'(v);
    return (w > CMP_W'(cacp_pkg::VOL_MAX)) ? cacp_pkg::VOL_MAX : VW'(w);
  endfunction

  // latched item
  cacp_pkg::op_e           op_q;
  logic [PW-1:0]           price_q;
  logic                    price_ok_q;
  // book extremes
  logic [PW-1:0]           highest_q, lowest_q;
  logic                    bid_seen_q, ask_seen_q;
  // sweep pointer and walk state
  logic [ADDR_W-1:0]       ptr_q;
  logic signed [G_W-1:0]   g_q, pg_q;
  logic [ACC_W-1:0]        d_q, s_q, pd_q, ps_q;
  logic                    dir_q, first_q;
  logic                    bid_rv_q, ask_rv_q;
  cacp_pkg::out_item_t     out_q;

  logic [ADDR_W-1:0]       bid_raddr, ask_raddr, waddr;
  logic                    bid_rok, ask_rok;
  logic [COUNT_BITS-1:0]   bid_rdata, ask_rdata, bid_val, ask_val;
  logic [COUNT_BITS-1:0]   bid_inc, ask_inc, bid_wdata, ask_wdata;
  logic                    bid_we, ask_we;
  logic                    in_price_ok;
  logic                    d_gt_s, d_lt_s;
  logic [ACC_W-1:0]        mprev, mcur;

  assign in_price_ok = int'(in_item_i.price) < PRICE_LEVELS;

  // bid read address select
  always_comb begin
    bid_raddr = ptr_q;
    bid_rok   = 1'b1;
    unique case (cmd_i.bid_rsel)
      cacp_pkg::RSEL_IN: begin
        bid_raddr = ADDR_W'(in_item_i.price);
        bid_rok   = in_price_ok;
      end
      cacp_pkg::RSEL_PTR: begin
        bid_raddr = ptr_q;
        bid_rok   = 1'b1;
      end
      cacp_pkg::RSEL_G: begin
        bid_raddr = g_addr(g_q);
        bid_rok   = g_in_range(g_q);
      end
      cacp_pkg::RSEL_PG: begin
        bid_raddr = g_addr(pg_q);
        bid_rok   = g_in_range(pg_q);
      end
      default: begin
        bid_rok = 1'b0;
      end
    endcase
  end

  // ask read address select
  always_comb begin
    ask_raddr = ptr_q;
    ask_rok   = 1'b1;
    unique case (cmd_i.ask_rsel)
      cacp_pkg::RSEL_IN: begin
        ask_raddr = ADDR_W'(in_item_i.price);
        ask_rok   = in_price_ok;
      end
      cacp_pkg::RSEL_PTR: begin
        ask_raddr = ptr_q;
        ask_rok   = 1'b1;
      end
      cacp_pkg::RSEL_G: begin
        ask_raddr = g_addr(g_q);
        ask_rok   = g_in_range(g_q);
      end
      cacp_pkg::RSEL_PG: begin
        ask_raddr = g_addr(pg_q);
        ask_rok   = g_in_range(pg_q);
      end
      default: begin
        ask_rok = 1'b0;
      end
    endcase
  end

  // write side: clearing sweep or saturating increment
  assign bid_inc   = (bid_rdata == '1) ? bid_rdata : bid_rdata + 1'b1;
  assign ask_inc   = (ask_rdata == '1) ? ask_rdata : ask_rdata + 1'b1;
  assign waddr     = cmd_i.clr_wr ? ptr_q : ADDR_W'(price_q);
  assign bid_wdata = cmd_i.clr_wr ? '0 : bid_inc;
  assign ask_wdata = cmd_i.clr_wr ? '0 : ask_inc;
  assign bid_we    = cmd_i.clr_wr ||
                     (cmd_i.add_wr && price_ok_q && (op_q == cacp_pkg::OP_ADD_BID));
  assign ask_we    = cmd_i.clr_wr ||
                     (cmd_i.add_wr && price_ok_q && (op_q == cacp_pkg::OP_ADD_ASK));

  cacp_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (PRICE_LEVELS)
  ) u_bid_ram (
    .clk_i   (clk_i),
    .we_i    (bid_we),
    .waddr_i (waddr),
    .wdata_i (bid_wdata),
    .raddr_i (bid_raddr),
    .rdata_o (bid_rdata)
  );

  cacp_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (PRICE_LEVELS)
  ) u_ask_ram (
    .clk_i   (clk_i),
    .we_i    (ask_we),
    .waddr_i (waddr),
    .wdata_i (ask_wdata),
    .raddr_i (ask_raddr),
    .rdata_o (ask_rdata)
  );

  // bins outside the price range read as zero
  assign bid_val = bid_rv_q ? bid_rdata : '0;
  assign ask_val = ask_rv_q ? ask_rdata : '0;

  // walk comparisons
  assign d_gt_s = d_q > s_q;
  assign d_lt_s = d_q < s_q;
  assign mprev  = dir_q ? ps_q : pd_q;
  assign mcur   = d_gt_s ? s_q : d_q;

  assign sts_o.crossed     = bid_seen_q && ask_seen_q && (highest_q > lowest_q);
  assign sts_o.ptr_at_hi   = ptr_q == ADDR_W'(highest_q);
  assign sts_o.ptr_at_end  = ptr_q == ADDR_W'(PRICE_LEVELS - 1);
  assign sts_o.d_eq_s      = d_q == s_q;
  assign sts_o.flip        = !first_q && ((d_gt_s && !dir_q) || (d_lt_s && dir_q));
  assign sts_o.dir_up      = dir_q;
  assign sts_o.prev_better = mprev > mcur;

  // control registers: book extremes, pointer, read flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      highest_q  <= '0;
      lowest_q   <= '1;
      bid_seen_q <= 1'b0;
      ask_seen_q <= 1'b0;
      ptr_q      <= '0;
      bid_rv_q   <= 1'b0;
      ask_rv_q   <= 1'b0;
    end else begin
      bid_rv_q <= cmd_i.bid_rd && bid_rok;
      ask_rv_q <= cmd_i.ask_rd && ask_rok;
      if (cmd_i.book_clear) begin
        highest_q  <= '0;
        lowest_q   <= '1;
        bid_seen_q <= 1'b0;
        ask_seen_q <= 1'b0;
      end else if (cmd_i.add_wr && price_ok_q) begin
        if (op_q == cacp_pkg::OP_ADD_BID) begin
          if (!bid_seen_q || (price_q > highest_q)) begin
            highest_q <= price_q;
          end
          bid_seen_q <= 1'b1;
        end else begin
          if (!ask_seen_q || (price_q < lowest_q)) begin
            lowest_q <= price_q;
          end
          ask_seen_q <= 1'b1;
        end
      end
      if (cmd_i.ptr_zero) begin
        ptr_q <= '0;
      end else if (cmd_i.walk_init) begin
        ptr_q <= ADDR_W'(lowest_q);
      end else if (cmd_i.ptr_inc) begin
        ptr_q <= ptr_q + 1'b1;
      end
    end
  end

  // payload registers: item, walk state, result
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q       <= in_item_i.operation;
      price_q    <= in_item_i.price;
      price_ok_q <= in_price_ok;
    end
    if (cmd_i.walk_init) begin
      g_q     <= G_W'(lowest_q);
      pg_q    <= G_W'(lowest_q);
      d_q     <= '0;
      s_q     <= '0;
      first_q <= 1'b1;
    end else if (cmd_i.step) begin
      pd_q    <= d_q;
      ps_q    <= s_q;
      pg_q    <= g_q;
      dir_q   <= d_gt_s;
      g_q     <= d_gt_s ? g_q + G_ONE : g_q - G_ONE;
      first_q <= 1'b0;
    end else begin
      case (cmd_i.acc)
        cacp_pkg::ACC_SUM: begin
          if (bid_rv_q) begin
            d_q <= d_q + ACC_W'(bid_val);
          end
          if (ask_rv_q) begin
            s_q <= ACC_W'(ask_val);
          end
        end
        cacp_pkg::ACC_STEP: begin
          if (dir_q) begin
            s_q <= s_q + ACC_W'(ask_val);
            d_q <= d_q - ACC_W'(bid_val);
          end else begin
            s_q <= s_q - ACC_W'(ask_val);
            d_q <= d_q + ACC_W'(bid_val);
          end
        end
        default: begin
        end
      endcase
    end
    if (cmd_i.out_load) begin
      case (cmd_i.out_sel)
        cacp_pkg::RES_CUR: begin
          out_q.clear_price    <= g_q[PW-1:0];
          out_q.matched_demand <= sat_vol(d_q);
          out_q.matched_supply <= sat_vol(s_q);
          out_q.crossed        <= 1'b1;
        end
        cacp_pkg::RES_PREV: begin
          out_q.clear_price    <= pg_q[PW-1:0];
          out_q.matched_demand <= sat_vol(pd_q);
          out_q.matched_supply <= sat_vol(ps_q);
          out_q.crossed        <= 1'b1;
        end
        default: begin
          out_q <= '0;
        end
      endcase
    end
  end

  assign out_item_o = out_q;

endmodule

FILE: sv/call_auction_clearing_price.sv
// top level of the call auction clearing price block
//
// Input channel (in_valid_i / in_ready_o / in_item_i) takes one order per
// transfer: add bid, add ask, solve or clear book. Only a solve gives a
// result, one transfer on the output channel (out_valid_o / out_ready_i /
// out_item_o) holding the clearing price, matched volumes and crossed flag.
// An add reads the bin and then writes it back incremented. A crossed
// solve sums the demand and then walks the clearing price, with a pick
// between the previous and current step when the walk ends on a sign
// flip; the next order is taken as soon as the result shows. The demand
// sum reads one bid bin a cycle, and each walk step is a read, an update
// and a compare on the two histogram rams. An uncrossed book answers with
// an all zero result and no walk. A clear book, and reset, sweep zeros
// through both histograms one address a cycle with in_ready_o low.
// The result sits in an output register: a waiting result does not
// block the next add, only the next solve waits for the receiver to take it.
module call_auction_clearing_price #(
  parameter int PRICE_LEVELS = 1024,
  parameter int COUNT_BITS   = 20
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  cacp_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cacp_pkg::out_item_t out_item_o
);

  cacp_pkg::cmd_t cmd;
  cacp_pkg::sts_t sts;

  // sequencing
  cacp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (in_item_i.operation),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // histograms and walk arithmetic
  cacp_dp #(
    .PRICE_LEVELS (PRICE_LEVELS),
    .COUNT_BITS   (COUNT_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_item_o (out_item_o)
  );

endmodule

FILE: sv/cacp_checker.sv
// port level checks of the call auction clearing price block and their bind
module cacp_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input cacp_pkg::in_item_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input cacp_pkg::out_item_t out_item_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // every accepted item keeps the block busy in the cycle after it
  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after a transfer");

  // an uncrossed book reports all zero
  a_uncrossed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.crossed |->
      out_item_o.clear_price == '0 && out_item_o.matched_demand == '0 &&
      out_item_o.matched_supply == '0)
    else $error("uncrossed result not zero");

  // only a solve can raise a result
  a_no_result_from_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_item_i.operation != cacp_pkg::OP_SOLVE |=>
      !$rose(out_valid_o))
    else $error("result raised by a non solve item");

endmodule

bind call_auction_clearing_price cacp_checker u_cacp_checker (.*);
